/* rtl/core/avtb_pkg.sv */
// Shared types, constants and arithmetic helpers for the vertex transform and box unit.
`timescale 1ns / 1ps

package avtb_pkg;

  localparam int COORD_BITS = 24;
  localparam int COEFF_BITS = 16;
  localparam int COORD_FRAC = 8;
  localparam int COEFF_FRAC = COEFF_BITS / 2;
  localparam int ROW_BITS   = 4 * COEFF_BITS;
  localparam int CFG_BITS   = 64;
  localparam int CFG_IDX_BITS = 2;
  localparam int PROD_BITS  = COORD_BITS + COEFF_BITS;
  localparam int ACC_BITS   = PROD_BITS + 2;

  // Identity matrix at reset
  localparam logic [ROW_BITS-1:0] ROW_X_RESET = ROW_BITS'(1) << (0 * COEFF_BITS + COEFF_FRAC);
  localparam logic [ROW_BITS-1:0] ROW_Y_RESET = ROW_BITS'(1) << (1 * COEFF_BITS + COEFF_FRAC);
  localparam logic [ROW_BITS-1:0] ROW_Z_RESET = ROW_BITS'(1) << (2 * COEFF_BITS + COEFF_FRAC);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COEFF_BITS-1:0] coeff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [ACC_BITS-1:0]   acc_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ROW_X = 2'd0,
    CFG_ROW_Y = 2'd1,
    CFG_ROW_Z = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    coord_t vertex_z;
    logic   first_vertex;
    logic   last_vertex;
  } vertex_in_t;

  typedef struct packed {
    coord_t moved_x;
    coord_t moved_y;
    coord_t moved_z;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
    logic   box_done;
  } vertex_out_t;

  function automatic coeff_t row_coeff(input logic [ROW_BITS-1:0] row, input int k);
    return coeff_t'(row[k*COEFF_BITS +: COEFF_BITS]);
  endfunction

  // Round half up, drop coefficient fraction bits, clamp to coordinate range
  function automatic coord_t round_sat(input acc_t acc);
    acc_t shifted;
    shifted = (acc + acc_t'(1 <<< (COEFF_FRAC - 1))) >>> COEFF_FRAC;
    if (shifted > acc_t'(COORD_MAX)) begin
      return COORD_MAX;
    end else if (shifted < acc_t'(COORD_MIN)) begin
      return COORD_MIN;
    end else begin
      return coord_t'(shifted);
    end
  endfunction

endpackage

/* rtl/core/affine_vertex_transform_bbox_unit.sv */
// Top level: affine vertex transform with running axis-aligned bounding box.
`timescale 1ns / 1ps

// Transforms one signed Q16.8 vertex per item by three programmable rows of
// Q8.8 coefficients (x, y, z multipliers and a translation, w taken as 1),
// rounding half up and saturating each coordinate to 24 bits, and returns
// the transformed vertex with the bounding box of all vertices since the
// last first_vertex flag. The unit takes one item per clock cycle unless the
// output stalls, through a multiply stage of nine 16x24 products, a sum,
// round and saturate stage, and the result register, whose loading also
// updates the running box. Each stage moves forward whenever it is empty
// or the stage after it moves, so up to two more items enter while a result
// waits; after that in_ready drops until the result is taken.
// Program the rows only when no item is in flight; reset loads identity.
module affine_vertex_transform_bbox_unit
  import avtb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  vertex_in_t              in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output vertex_out_t             out_item
);

  logic [ROW_BITS-1:0] rows [3];

  // Product stage
  logic  p_valid;
  prod_t p_prod [3][3];
  logic  p_first;
  logic  p_last;

  // Sum stage
  logic   s_valid;
  coord_t s_moved [3];
  logic   s_first;
  logic   s_last;

  // Result stage
  coord_t moved [3];
  logic   done;
  coord_t running_min [3];
  coord_t running_max [3];
  coord_t running_min_next [3];
  coord_t running_max_next [3];

  logic out_open;
  logic s_open;
  logic out_load;
  logic s_load;

  coord_t in_coord [3];
  coord_t sum_coord [3];

  assign out_open = !out_valid || out_ready;
  assign s_open   = !s_valid || out_open;
  assign in_ready = !p_valid || s_open;
  assign out_load = s_valid && out_open;
  assign s_load   = p_valid && s_open;

  assign in_coord[0] = in_item.vertex_x;
  assign in_coord[1] = in_item.vertex_y;
  assign in_coord[2] = in_item.vertex_z;

  // Configuration rows
  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= ROW_X_RESET;
      rows[1] <= ROW_Y_RESET;
      rows[2] <= ROW_Z_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ROW_X: rows[0] <= cfg_data[ROW_BITS-1:0];
        CFG_ROW_Y: rows[1] <= cfg_data[ROW_BITS-1:0];
        CFG_ROW_Z: rows[2] <= cfg_data[ROW_BITS-1:0];
        default:   ;
      endcase
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        p_valid <= in_valid;
      end
      if (s_open) begin
        s_valid <= p_valid;
      end
      if (out_open) begin
        out_valid <= s_valid;
      end
    end
  end

  // Multiply
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          p_prod[r][k] <= prod_t'(row_coeff(rows[r], k)) * prod_t'(in_coord[k]);
        end
      end
      p_first <= in_item.first_vertex;
      p_last  <= in_item.last_vertex;
    end
  end

  // Sum, round, saturate
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_coord[r] = round_sat(acc_t'(p_prod[r][0]) + acc_t'(p_prod[r][1])
                               + acc_t'(p_prod[r][2])
                               + (acc_t'(row_coeff(rows[r], 3)) <<< COORD_FRAC));
    end
  end

  always_ff @(posedge clk) begin
    if (s_load) begin
      s_moved <= sum_coord;
      s_first <= p_first;
      s_last  <= p_last;
    end
  end

  // Box update; a first flag restarts the box at this vertex
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (s_first) begin
        running_min_next[k] = s_moved[k];
        running_max_next[k] = s_moved[k];
      end else begin
        running_min_next[k] = (s_moved[k] < running_min[k]) ? s_moved[k] : running_min[k];
        running_max_next[k] = (s_moved[k] > running_max[k]) ? s_moved[k] : running_max[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        running_min[k] <= COORD_MAX;
        running_max[k] <= COORD_MIN;
      end
    end else if (out_load) begin
      running_min <= running_min_next;
      running_max <= running_max_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      moved <= s_moved;
      done  <= s_last;
    end
  end

  // The box registers load together with the result, so they hold with it
  assign out_item.moved_x   = moved[0];
  assign out_item.moved_y   = moved[1];
  assign out_item.moved_z   = moved[2];
  assign out_item.box_min_x = running_min[0];
  assign out_item.box_min_y = running_min[1];
  assign out_item.box_min_z = running_min[2];
  assign out_item.box_max_x = running_max[0];
  assign out_item.box_max_y = running_max[1];
  assign out_item.box_max_z = running_max[2];
  assign out_item.box_done  = done;

`ifndef SYNTHESIS
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> p_valid)
    else $error("accepted item did not enter the product stage");

  a_first_collapses_box: assert property (@(posedge clk) disable iff (rst)
    out_load && s_first |=> running_min[0] == running_max[0]
      && running_min[1] == running_max[1] && running_min[2] == running_max[2])
    else $error("first vertex did not restart the box");

  a_vertex_in_box: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.box_min_x <= out_item.moved_x
      && out_item.moved_x <= out_item.box_max_x
      && out_item.box_min_y <= out_item.moved_y
      && out_item.moved_y <= out_item.box_max_y
      && out_item.box_min_z <= out_item.moved_z
      && out_item.moved_z <= out_item.box_max_z)
    else $error("transformed vertex lies outside its box");
`endif

endmodule

/* tb/affine_vertex_transform_bbox_unit_test.sv */
// Self-checking testbench for the affine vertex transform and bounding box unit.
`timescale 1ns / 1ps

module affine_vertex_transform_bbox_unit_test;
  import avtb_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 7;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 250;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = CFG_IDX_BITS'(3);

  // Tracks the matrix and running box, and holds the transformed vertices still owed.
  class transformed_box_tracker;
    logic [ROW_BITS-1:0] rows[3];
    coord_t box_lo[3];
    coord_t box_hi[3];
    vertex_out_t expected_vertices[$];
    int errors;

    function new();
      rows[0] = ROW_X_RESET;
      rows[1] = ROW_Y_RESET;
      rows[2] = ROW_Z_RESET;
      for (int k = 0; k < 3; k++) begin
        box_lo[k] = COORD_MAX;
        box_hi[k] = COORD_MIN;
      end
      errors = 0;
    endfunction

    function void write_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
      case (idx)
        CFG_ROW_X: rows[0] = value;
        CFG_ROW_Y: rows[1] = value;
        CFG_ROW_Z: rows[2] = value;
        default: ;  // drop writes to the unused index
      endcase
    endfunction

    function coord_t transform_axis(logic [ROW_BITS-1:0] row, vertex_in_t v);
      coeff_t cx;
      coeff_t cy;
      coeff_t cz;
      coeff_t offset;
      longint acc;
      cx     = row[0 +: COEFF_BITS];
      cy     = row[COEFF_BITS +: COEFF_BITS];
      cz     = row[2*COEFF_BITS +: COEFF_BITS];
      offset = row[3*COEFF_BITS +: COEFF_BITS];
      acc = longint'(cx) * longint'(v.vertex_x) + longint'(cy) * longint'(v.vertex_y)
          + longint'(cz) * longint'(v.vertex_z) + longint'(offset) * (longint'(1) << COORD_FRAC)
          + (longint'(1) << (COEFF_FRAC - 1));
      // arithmetic shift floors, so with the half bias added this rounds half up
      acc = acc >>> COEFF_FRAC;
      if (acc > longint'(COORD_MAX)) return COORD_MAX;
      if (acc < longint'(COORD_MIN)) return COORD_MIN;
      return coord_t'(acc);
    endfunction

    function void note_vertex(vertex_in_t v);
      coord_t moved[3];
      vertex_out_t e;
      for (int k = 0; k < 3; k++) begin
        moved[k] = transform_axis(rows[k], v);
        if (v.first_vertex) begin
          box_lo[k] = moved[k];
          box_hi[k] = moved[k];
        end else begin
          if (moved[k] < box_lo[k]) box_lo[k] = moved[k];
          if (moved[k] > box_hi[k]) box_hi[k] = moved[k];
        end
      end
      e.moved_x   = moved[0];
      e.moved_y   = moved[1];
      e.moved_z   = moved[2];
      e.box_min_x = box_lo[0];
      e.box_min_y = box_lo[1];
      e.box_min_z = box_lo[2];
      e.box_max_x = box_hi[0];
      e.box_max_y = box_hi[1];
      e.box_max_z = box_hi[2];
      e.box_done  = v.last_vertex;
      expected_vertices.push_back(e);
    endfunction

    function void check_field(string name, longint want, longint seen);
      if (want != seen) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(vertex_out_t got);
      vertex_out_t want;
      if (expected_vertices.size() == 0) begin
        $display("%0t: result item expected none got %h", $time, got);
        errors++;
        return;
      end
      want = expected_vertices.pop_front();
      check_field("moved_x", want.moved_x, got.moved_x);
      check_field("moved_y", want.moved_y, got.moved_y);
      check_field("moved_z", want.moved_z, got.moved_z);
      check_field("box_min_x", want.box_min_x, got.box_min_x);
      check_field("box_min_y", want.box_min_y, got.box_min_y);
      check_field("box_min_z", want.box_min_z, got.box_min_z);
      check_field("box_max_x", want.box_max_x, got.box_max_x);
      check_field("box_max_y", want.box_max_y, got.box_max_y);
      check_field("box_max_z", want.box_max_z, got.box_max_z);
      check_field("box_done", want.box_done, got.box_done);
    endfunction
  endclass

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_ROW_X;
  logic [CFG_BITS-1:0]     cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  vertex_in_t              in_item   = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  vertex_out_t             out_item;

  transformed_box_tracker tracker = new();
  int in_gap_max  = 7;
  int out_gap_max = 7;
  int idle_cycles = 0;

  affine_vertex_transform_bbox_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int draw_gap(int limit);
    return (limit == 0) ? 0 : int'($urandom_range(0, limit));
  endfunction

  function automatic vertex_in_t make_vertex(coord_t x, coord_t y, coord_t z,
                                             logic first, logic last);
    vertex_in_t v;
    v.vertex_x     = x;
    v.vertex_y     = y;
    v.vertex_z     = z;
    v.first_vertex = first;
    v.last_vertex  = last;
    return v;
  endfunction

  function automatic logic [ROW_BITS-1:0] pack_row(coeff_t cx, coeff_t cy, coeff_t cz,
                                                   coeff_t offset);
    return {offset, cz, cy, cx};
  endfunction

  function automatic coord_t random_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2, 3, 4: return coord_t'($urandom);
      default: return coord_t'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic coeff_t random_coeff();
    case ($urandom_range(0, 7))
      0, 1: return coeff_t'($urandom);
      2: return coeff_t'(16'h7FFF);
      3: return coeff_t'(16'h8000);
      4: return '0;
      default: return coeff_t'(int'($urandom_range(0, 1024)) - 512);
    endcase
  endfunction

  function automatic logic [ROW_BITS-1:0] random_row();
    return pack_row(random_coeff(), random_coeff(), random_coeff(), random_coeff());
  endfunction

  task automatic send_vertex(vertex_in_t v);
    int gap;
    gap = draw_gap(in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    tracker.note_vertex(v);
  endtask

  task automatic wait_drained();
    while (tracker.expected_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Program all three rows back to back, then poke the unused index.
  task automatic load_matrix(logic [ROW_BITS-1:0] rx, logic [ROW_BITS-1:0] ry,
                             logic [ROW_BITS-1:0] rz);
    logic [CFG_BITS-1:0] rows[3];
    cfg_idx_t order[3];
    logic [CFG_BITS-1:0] junk;
    rows  = '{rx, ry, rz};
    order = '{CFG_ROW_X, CFG_ROW_Y, CFG_ROW_Z};
    junk  = {$urandom, $urandom};
    in_valid <= 1'b0;
    wait_drained();
    cfg_wr_en <= 1'b1;
    for (int k = 0; k < 3; k++) begin
      cfg_index <= order[k];
      cfg_data  <= rows[k];
      @(posedge clk);
      tracker.write_register(order[k], rows[k]);
    end
    cfg_index <= CFG_UNUSED;
    cfg_data  <= junk;
    @(posedge clk);
    tracker.write_register(CFG_UNUSED, junk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly well-formed meshes; now and then one with random flags.
  task automatic send_meshes(int count);
    int sent = 0;
    int len;
    bit noise;
    vertex_in_t v;
    while (sent < count) begin
      len   = $urandom_range(1, 12);
      noise = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++) begin
        v = make_vertex(random_coord(), random_coord(), random_coord(),
                        noise ? 1'($urandom) : (i == 0),
                        noise ? 1'($urandom) : (i == len - 1));
        send_vertex(v);
      end
      sent += len;
    end
  endtask

  initial begin : result_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap(out_gap_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      tracker.check_result(out_item);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Identity after reset; the box starts from the reset extremes with no first flag.
    send_vertex(make_vertex(0, 0, 0, 1'b0, 1'b0));
    send_vertex(make_vertex(COORD_MAX, COORD_MIN, 1, 1'b0, 1'b0));
    send_vertex(make_vertex(COORD_MIN, COORD_MAX, -1, 1'b0, 1'b1));
    // keep accumulating after a last flag
    send_vertex(make_vertex(5, -5, 7, 1'b0, 1'b0));
    // single-vertex mesh
    send_vertex(make_vertex(100, 200, -300, 1'b1, 1'b1));
    send_vertex(make_vertex(-1, -1, -1, 1'b1, 1'b0));
    send_vertex(make_vertex(1, 2, 3, 1'b0, 1'b0));
    send_vertex(make_vertex(-2, -3, -4, 1'b0, 1'b1));

    // Largest positive coefficients everywhere: saturate both ways.
    load_matrix(pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF),
                pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF),
                pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_vertex(make_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b0));
    send_vertex(make_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b0));
    send_vertex(make_vertex(0, 0, 0, 1'b0, 1'b0));
    send_vertex(make_vertex(1, -1, 0, 1'b0, 1'b1));

    // Most negative coefficients, all-ones and all-zero registers.
    load_matrix(pack_row(16'h8000, 16'h8000, 16'h8000, 16'h8000), '1, '0);
    send_vertex(make_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b0));
    send_vertex(make_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b0));
    send_vertex(make_vertex(0, 0, 0, 1'b0, 1'b0));
    send_vertex(make_vertex(-1, 1, -1, 1'b0, 1'b1));

    // Half-step products to hit the round-half-up boundary, with extreme offsets.
    load_matrix(pack_row(16'h0080, 16'h0000, 16'h0000, 16'h0000),
                pack_row(16'h0000, 16'hFF80, 16'h0000, 16'h8000),
                pack_row(16'h0000, 16'h0000, 16'h0180, 16'h7FFF));
    send_vertex(make_vertex(1, -1, 1, 1'b1, 1'b0));
    send_vertex(make_vertex(-1, 1, -1, 1'b0, 1'b0));
    send_vertex(make_vertex(3, -3, 3, 1'b0, 1'b0));
    send_vertex(make_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, 1'b1));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      in_gap_max  = (p % 2 == 1) ? 7 : 0;
      out_gap_max = ((p / 2) % 2 == 1) ? 7 : 0;
      load_matrix(random_row(), random_row(), random_row());
      send_meshes(PHASE_ITEMS);
    end

    in_valid <= 1'b0;
    wait_drained();
    if (tracker.errors == 0 && tracker.expected_vertices.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
